// ----- hw/rtl/hash_insert_linear_probe_defines.svh -----
// assertion macros shared by the hash insert rtl
// depends on nothing; included by files that carry assertions
`ifndef HASH_INSERT_LINEAR_PROBE_DEFINES_SVH
`define HASH_INSERT_LINEAR_PROBE_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define HILP_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hilp assertion failed");

// next-cycle implication, disabled while reset is asserted
`define HILP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hilp assertion failed");

`endif

// ----- hw/rtl/hilp_pkg.sv -----
// shared types and constants for the linear probing hash insert block
// no dependencies
package hilp_pkg;

  localparam int KEY_W    = 16;
  localparam int CFG_W    = 5;
  localparam int STATUS_W = 2;
  localparam int SLOT_W   = 4;
  localparam int QDEPTH   = 2;
  localparam logic [CFG_W-1:0] CFG_SIZE_RST = 5'd15;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED = 2'd0,
    ST_PRESENT  = 2'd1,
    ST_FULL     = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_DIV,
    F_PUSH
  } front_state_t;

  typedef enum logic {
    B_IDLE,
    B_CHECK
  } back_state_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage

// ----- hw/rtl/hilp_ram.sv -----
// generic single write port ram with registered read
// no dependencies
module hilp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- hw/rtl/hilp_queue.sv -----
// short fifo between the hashing front end and the probe engine
// depends on hilp_pkg
module hilp_queue
  import hilp_pkg::*;
#(
  parameter int WIDTH = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output qstat_t           qstat
);

  localparam int PW = $clog2(QDEPTH);
  localparam int CW = $clog2(QDEPTH + 1);

  logic [WIDTH-1:0] mem_r [QDEPTH];
  logic [PW-1:0]    wp_r, wp_nxt;
  logic [PW-1:0]    rp_r, rp_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign qstat.full  = (cnt_r == CW'(QDEPTH));
  assign qstat.empty = (cnt_r == '0);
  assign do_push     = push && !qstat.full;
  assign do_pop      = pop && !qstat.empty;
  assign dout        = mem_r[rp_r];

  always_comb begin
    wp_nxt  = do_push ? wp_r + 1'b1 : wp_r;
    rp_nxt  = do_pop ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= din;
    end
  end

endmodule

// ----- hw/rtl/hilp_front.sv -----
// front end: takes a key, computes its home slot with a bit-serial modulo
// depends on hilp_pkg
module hilp_front
  import hilp_pkg::*;
#(
  parameter int KW    = 16,
  parameter int DEPTH = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic [KEY_W-1:0]                 key,
  input  logic [$clog2(DEPTH+1)-1:0]       eff_size,
  input  qstat_t                           qstat,
  output logic                             busy,
  output logic                             push,
  output logic [KW-1:0]                    push_key,
  output logic [$clog2(DEPTH)-1:0]         push_home,
  output logic [$clog2(DEPTH+1)-1:0]       push_size
);

  localparam int IW  = $clog2(DEPTH);
  localparam int SZW = $clog2(DEPTH + 1);
  localparam int NW  = $clog2(KW);

  front_state_t   state_r, state_nxt;
  logic [KW-1:0]  sh_r, sh_nxt;
  logic [SZW-1:0] rem_r, rem_nxt;
  logic [SZW-1:0] size_r, size_nxt;
  logic [NW-1:0]  cnt_r, cnt_nxt;
  logic [SZW:0]   trial;

  // one quotient bit per cycle, msb first
  assign trial = {rem_r, sh_r[KW-1]};

  always_comb begin
    state_nxt = state_r;
    sh_nxt    = sh_r;
    rem_nxt   = rem_r;
    size_nxt  = size_r;
    cnt_nxt   = cnt_r;
    push      = 1'b0;
    unique case (state_r)
      F_IDLE: begin
        if (start) begin
          sh_nxt    = key[KW-1:0];
          rem_nxt   = '0;
          size_nxt  = eff_size;
          cnt_nxt   = NW'(KW - 1);
          state_nxt = F_DIV;
        end
      end
      F_DIV: begin
        // rotate so the key is back in place after the last step
        sh_nxt = {sh_r[KW-2:0], sh_r[KW-1]};
        if (trial >= {1'b0, size_r}) begin
          rem_nxt = SZW'(trial - {1'b0, size_r});
        end else begin
          rem_nxt = trial[SZW-1:0];
        end
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = F_PUSH;
        end
      end
      F_PUSH: begin
        if (!qstat.full) begin
          push      = 1'b1;
          state_nxt = F_IDLE;
        end
      end
      default: begin
        state_nxt = F_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sh_r   <= sh_nxt;
    rem_r  <= rem_nxt;
    size_r <= size_nxt;
    cnt_r  <= cnt_nxt;
  end

  assign busy      = (state_r != F_IDLE);
  assign push_key  = sh_r;
  assign push_home = rem_r[IW-1:0];
  assign push_size = size_r;

endmodule

// ----- hw/rtl/hilp_back.sv -----
// probe engine: walks the table from the home slot, inserts or finds the key
// depends on hilp_pkg, hilp_ram and the assertion macro header
`include "hash_insert_linear_probe_defines.svh"

module hilp_back
  import hilp_pkg::*;
#(
  parameter int KW    = 16,
  parameter int DEPTH = 16
) (
  input  logic                                               clk,
  input  logic                                               rst_n,
  input  qstat_t                                             qstat,
  input  logic [KW+$clog2(DEPTH)+$clog2(DEPTH+1)-1:0]        q_dout,
  output logic                                               q_pop,
  output logic                                               out_valid,
  output logic [STATUS_W-1:0]                                out_status,
  output logic [SLOT_W-1:0]                                  out_slot
);

  localparam int IW  = $clog2(DEPTH);
  localparam int SZW = $clog2(DEPTH + 1);

  back_state_t       state_r, state_nxt;
  logic [KW-1:0]     key_r, key_nxt;
  logic [IW-1:0]     idx_r, idx_nxt;
  logic [SZW-1:0]    size_r, size_nxt;
  logic [SZW-1:0]    n_r, n_nxt;
  logic [DEPTH-1:0]  valid_r;
  logic              ov_r, ov_nxt;
  status_t           status_r, status_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;

  logic [KW-1:0]        e_key;
  logic [IW-1:0]        e_home;
  logic [SZW-1:0]       e_size;
  logic [IW-1:0]        raddr;
  logic                 we;
  logic [KW-1:0]        rdata;
  logic [SZW-1:0]       idx_inc;
  logic [IW-1:0]        idx_wrap;
  logic                 last;
  logic [IW+SLOT_W-1:0] slot_ext;

  assign {e_key, e_home, e_size} = q_dout;

  assign idx_inc  = SZW'(idx_r) + 1'b1;
  assign idx_wrap = (idx_inc >= size_r) ? '0 : idx_inc[IW-1:0];
  assign last     = (n_r == size_r - 1'b1);
  assign slot_ext = {{SLOT_W{1'b0}}, idx_r};

  hilp_ram #(
    .WIDTH (KW),
    .DEPTH (DEPTH)
  ) u_keys (
    .clk   (clk),
    .we    (we),
    .waddr (idx_r),
    .wdata (key_r),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    state_nxt  = state_r;
    key_nxt    = key_r;
    idx_nxt    = idx_r;
    size_nxt   = size_r;
    n_nxt      = n_r;
    raddr      = idx_r;
    q_pop      = 1'b0;
    we         = 1'b0;
    ov_nxt     = 1'b0;
    status_nxt = status_r;
    slot_nxt   = slot_r;
    unique case (state_r)
      B_IDLE: begin
        if (!qstat.empty) begin
          q_pop     = 1'b1;
          key_nxt   = e_key;
          idx_nxt   = e_home;
          size_nxt  = e_size;
          n_nxt     = '0;
          raddr     = e_home;
          state_nxt = B_CHECK;
        end
      end
      B_CHECK: begin
        // ram data belongs to idx_r in this state
        if (!valid_r[idx_r]) begin
          we         = 1'b1;
          ov_nxt     = 1'b1;
          status_nxt = ST_INSERTED;
          slot_nxt   = slot_ext[SLOT_W-1:0];
          state_nxt  = B_IDLE;
        end else if (rdata == key_r) begin
          ov_nxt     = 1'b1;
          status_nxt = ST_PRESENT;
          slot_nxt   = slot_ext[SLOT_W-1:0];
          state_nxt  = B_IDLE;
        end else if (last) begin
          ov_nxt     = 1'b1;
          status_nxt = ST_FULL;
          slot_nxt   = '0;
          state_nxt  = B_IDLE;
        end else begin
          idx_nxt = idx_wrap;
          n_nxt   = n_r + 1'b1;
          raddr   = idx_wrap;
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      valid_r <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
      if (we) begin
        valid_r[idx_r] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    key_r    <= key_nxt;
    idx_r    <= idx_nxt;
    size_r   <= size_nxt;
    n_r      <= n_nxt;
    status_r <= status_nxt;
    slot_r   <= slot_nxt;
  end

  assign out_valid  = ov_r;
  assign out_status = status_r;
  assign out_slot   = slot_r;

  `HILP_ASSERT_NOW(a_no_overwrite, clk, rst_n, we, !valid_r[idx_r])
  `HILP_ASSERT_NOW(a_probe_bound, clk, rst_n, state_r == B_CHECK, n_r < size_r)
  `HILP_ASSERT_NOW(a_idx_in_table, clk, rst_n, state_r == B_CHECK, SZW'(idx_r) < size_r)
  `HILP_ASSERT_NEXT(a_pop_probes, clk, rst_n, q_pop, state_r == B_CHECK)

endmodule

// ----- hw/rtl/hash_insert_linear_probe.sv -----
// Linear probing hash table insert.
// A key is offered on in_key with start; it is taken at a rising edge where
// start is high and busy is low. Each key yields exactly one result on
// out_status / out_slot, shown for a single cycle with out_valid high:
// inserted (slot written), already present (slot found) or full (slot 0).
// The receiver cannot stall; every result must be taken when shown.
// The home slot is the key modulo the table size, found by a bit-serial
// remainder unit taking one key bit per cycle, after which the key waits
// in a two-entry queue for the probe engine. The probe engine reads one
// slot per cycle from the key ram. busy stays high until the key is pushed
// to the queue, longer only while the queue is full, so a new key is taken
// only once the last one is queued. The probe walk of a key ends before the
// front end can push the next one, so it never holds the front end back.
// table_size is written with cfg_we / cfg_wdata; the user must do so only
// while the block is idle, as the block itself does not enforce this.
// Reset sets table_size to 15 and marks every slot empty at once.
// depends on hilp_pkg, hilp_front, hilp_queue, hilp_back
module hash_insert_linear_probe
  import hilp_pkg::*;
#(
  parameter int MAX_SLOTS = 16,
  parameter int KEY_BITS  = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [KEY_W-1:0]    in_key,
  output logic                out_valid,
  output logic [STATUS_W-1:0] out_status,
  output logic [SLOT_W-1:0]   out_slot,
  input  logic                cfg_we,
  input  logic [CFG_W-1:0]    cfg_wdata
);

  // table_size never exceeds 31, so no more slots than that are ever probed
  localparam int TBL_DEPTH = (MAX_SLOTS < 32) ? MAX_SLOTS : 32;
  localparam int KW        = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
  localparam int IW        = $clog2(TBL_DEPTH);
  localparam int SZW       = $clog2(TBL_DEPTH + 1);
  localparam int QW        = KW + IW + SZW;

  logic [CFG_W-1:0] cfg_size_r;
  logic [CFG_W:0]   size_ext;
  logic [CFG_W:0]   size_clamped;
  logic [SZW-1:0]   eff_size;

  qstat_t           qstat;
  logic             push, pop;
  logic [KW-1:0]    push_key;
  logic [IW-1:0]    push_home;
  logic [SZW-1:0]   push_size;
  logic [QW-1:0]    q_dout;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_size_r <= CFG_SIZE_RST;
    end else if (cfg_we) begin
      cfg_size_r <= cfg_wdata;
    end
  end

  // zero counts as one, large values clamp to the table depth
  assign size_ext = {1'b0, cfg_size_r};
  always_comb begin
    if (size_ext == '0) begin
      size_clamped = (CFG_W + 1)'(1);
    end else if (size_ext > (CFG_W + 1)'(TBL_DEPTH)) begin
      size_clamped = (CFG_W + 1)'(TBL_DEPTH);
    end else begin
      size_clamped = size_ext;
    end
  end
  assign eff_size = size_clamped[SZW-1:0];

  hilp_front #(
    .KW    (KW),
    .DEPTH (TBL_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .key       (in_key),
    .eff_size  (eff_size),
    .qstat     (qstat),
    .busy      (busy),
    .push      (push),
    .push_key  (push_key),
    .push_home (push_home),
    .push_size (push_size)
  );

  hilp_queue #(
    .WIDTH (QW)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .din   ({push_key, push_home, push_size}),
    .pop   (pop),
    .dout  (q_dout),
    .qstat (qstat)
  );

  hilp_back #(
    .KW    (KW),
    .DEPTH (TBL_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .qstat      (qstat),
    .q_dout     (q_dout),
    .q_pop      (pop),
    .out_valid  (out_valid),
    .out_status (out_status),
    .out_slot   (out_slot)
  );

endmodule
